// File: src/mqttdf_pkg.sv
// ----------------------------------------------------------------------------
// MQTT inbound deframer package
// Shared types and constants for the receive deframer and keepalive timer.
// ----------------------------------------------------------------------------
package mqttdf_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_TLEN_HI = 3'd2,
        PH_TLEN_LO = 3'd3,
        PH_TOPIC   = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_SKIP    = 3'd6
    } t_phase;

    // Result kinds
    localparam logic [1:0] KIND_TOPIC   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_TX      = 2'd2;

    // Packet types from the fixed header
    localparam logic [3:0] TYPE_PUBLISH = 4'd3;
    localparam logic [3:0] TYPE_PINGREQ = 4'd12;

    // Transmit bytes
    localparam logic [7:0] BYTE_PINGREQ  = 8'd192;
    localparam logic [7:0] BYTE_PINGRESP = 8'd208;

    localparam logic [16:0] IDLE_MAX = 17'h1FFFF;

    // Register map
    localparam logic [2:0] ADDR_KEEPALIVE = 3'd0;
    localparam logic [2:0] ADDR_MAX_BYTES = 3'd4;
    localparam logic [15:0] KEEPALIVE_RST = 16'd15000;
    localparam logic [15:0] MAX_BYTES_RST = 16'd128;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       topic_end;
        logic       packet_end;
    } t_result;

endpackage

// File: src/mqtt_inbound_deframer_keepalive.sv
// ----------------------------------------------------------------------------
// MQTT inbound deframer with keepalive
// Parses received MQTT packets, delivers PUBLISH topic and payload bytes,
// answers PINGREQ and sends a ping when the idle tick count expires.
// ----------------------------------------------------------------------------
// A result is registered in the result queue before it appears on the master side.
// Throughput: one input beat per cycle while the queue has room; each result
// takes one output beat, so an item with a transmit pair takes two beats. The
// four-entry result queue sets this: input is taken while it holds two or less.
// Reset (synchronous, active low) clears the parser, idle timer and queue and
// loads the registers with their defaults. There is no clearing pass.
module mqtt_inbound_deframer_keepalive
    import mqttdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_axis_tuser,   // [0] mode

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] topic_end, rest zero
    output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
    output logic        m_axis_tlast,   // packet_end

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers
    logic [15:0] r_keepalive;
    logic [15:0] r_max_bytes;

    // Parser state
    t_phase      r_phase,  n_phase;
    logic [3:0]  r_kind,   n_kind;
    logic [27:0] r_rem,    n_rem;
    logic [2:0]  r_grp,    n_grp;
    logic [2:0]  r_hbc,    n_hbc;
    logic [15:0] r_topic,  n_topic;
    logic        r_drop,   n_drop;
    logic [16:0] r_idle,   n_idle;

    // Result queue
    t_result     r_q [4];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_cnt;

    logic        w_in_acc;
    logic        w_out_acc;
    logic        w_tick;
    logic [7:0]  w_b;

    logic [27:0] w_rem_dec;
    logic        w_dec_zero;
    logic [15:0] w_topic_dec;
    logic [15:0] w_topic_lo;
    logic [27:0] w_len_grp;
    logic [27:0] w_len_rem;
    logic [2:0]  w_grp_inc;
    logic [2:0]  w_hbc_inc;
    logic        w_len_done;
    logic        w_len_drop;
    logic [28:0] w_total;
    logic [16:0] w_idle_inc;
    logic        w_tick_fire;

    logic [1:0]  w_res_cnt;
    t_result     w_res0, w_res1;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;
    assign w_tick    = s_axis_tuser[0];
    assign w_b       = s_axis_tdata;

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {16'd0, r_max_bytes} : {16'd0, r_keepalive};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keepalive <= KEEPALIVE_RST;
            r_max_bytes <= MAX_BYTES_RST;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == ADDR_MAX_BYTES[2]) begin
                r_max_bytes <= pwdata[15:0];
            end else begin
                r_keepalive <= pwdata[15:0];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared datapath
    // ------------------------------------------------------------------------
    assign w_rem_dec   = r_rem - 28'd1;
    assign w_dec_zero  = (w_rem_dec == 28'd0);
    assign w_topic_dec = r_topic - 16'd1;
    assign w_topic_lo  = {r_topic[15:8], w_b};

    // Length groups arrive least significant first, seven bits each.
    always_comb begin
        case (r_grp[1:0])
            2'd0:    w_len_grp = {21'd0, w_b[6:0]};
            2'd1:    w_len_grp = {14'd0, w_b[6:0], 7'd0};
            2'd2:    w_len_grp = {7'd0, w_b[6:0], 14'd0};
            default: w_len_grp = {w_b[6:0], 21'd0};
        endcase
    end

    assign w_len_rem  = r_rem | w_len_grp;
    assign w_grp_inc  = r_grp + 3'd1;
    assign w_hbc_inc  = r_hbc + 3'd1;
    // The length is complete after the fourth group whatever its top bit says.
    assign w_len_done = !w_b[7] || w_grp_inc[2];
    assign w_total    = {26'd0, w_hbc_inc} + {1'b0, w_len_rem};
    assign w_len_drop = w_total > {13'd0, r_max_bytes};

    assign w_idle_inc  = (r_idle < IDLE_MAX) ? r_idle + 17'd1 : r_idle;
    assign w_tick_fire = w_idle_inc > {1'b0, r_keepalive};

    // ------------------------------------------------------------------------
    // Results of the current item
    // ------------------------------------------------------------------------
    always_comb begin
        w_res_cnt = 2'd0;
        w_res0    = '{kind: KIND_TX, data: 8'd0, topic_end: 1'b0, packet_end: 1'b0};
        w_res1    = '{kind: KIND_TX, data: 8'd0, topic_end: 1'b0, packet_end: 1'b1};
        if (w_tick) begin
            if (w_tick_fire) begin
                w_res_cnt   = 2'd2;
                w_res0.data = BYTE_PINGREQ;
            end
        end else begin
            unique case (r_phase)
                PH_LENGTH: begin
                    if (w_len_done && w_len_rem == 28'd0 && !w_len_drop
                            && r_kind == TYPE_PINGREQ) begin
                        w_res_cnt   = 2'd2;
                        w_res0.data = BYTE_PINGRESP;
                    end
                end
                PH_TLEN_HI, PH_TLEN_LO, PH_SKIP: begin
                    if (w_dec_zero && !r_drop && r_kind == TYPE_PINGREQ) begin
                        w_res_cnt   = 2'd2;
                        w_res0.data = BYTE_PINGRESP;
                    end
                end
                PH_TOPIC: begin
                    w_res_cnt         = 2'd1;
                    w_res0.kind       = KIND_TOPIC;
                    w_res0.data       = w_b;
                    w_res0.topic_end  = (w_topic_dec == 16'd0) || w_dec_zero;
                    w_res0.packet_end = w_dec_zero;
                end
                PH_PAYLOAD: begin
                    w_res_cnt         = 2'd1;
                    w_res0.kind       = KIND_PAYLOAD;
                    w_res0.data       = w_b;
                    w_res0.packet_end = w_dec_zero;
                end
                default: begin
                    w_res_cnt = 2'd0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Parser next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_rem   = r_rem;
        n_grp   = r_grp;
        n_hbc   = r_hbc;
        n_topic = r_topic;
        n_drop  = r_drop;

        if (w_res_cnt == 2'd2) begin
            n_idle = 17'd0;
        end else if (w_tick) begin
            n_idle = w_idle_inc;
        end else begin
            n_idle = r_idle;
        end

        if (!w_tick) begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_kind  = w_b[7:4];
                    n_rem   = 28'd0;
                    n_grp   = 3'd0;
                    n_hbc   = 3'd1;
                    n_topic = 16'd0;
                    n_drop  = 1'b0;
                    n_phase = PH_LENGTH;
                end
                PH_LENGTH: begin
                    n_rem = w_len_rem;
                    n_grp = w_grp_inc;
                    n_hbc = w_hbc_inc;
                    if (w_len_done) begin
                        n_drop = w_len_drop;
                        if (w_len_rem == 28'd0) begin
                            n_phase = PH_HEADER;
                        end else if (w_len_drop || r_kind != TYPE_PUBLISH) begin
                            n_phase = PH_SKIP;
                        end else begin
                            n_phase = PH_TLEN_HI;
                        end
                    end
                end
                PH_TLEN_HI: begin
                    n_topic = {w_b, 8'd0};
                    n_rem   = w_rem_dec;
                    n_phase = w_dec_zero ? PH_HEADER : PH_TLEN_LO;
                end
                PH_TLEN_LO: begin
                    n_topic = w_topic_lo;
                    n_rem   = w_rem_dec;
                    if (w_dec_zero) begin
                        n_phase = PH_HEADER;
                    end else if (w_topic_lo == 16'd0) begin
                        n_phase = PH_PAYLOAD;
                    end else begin
                        n_phase = PH_TOPIC;
                    end
                end
                PH_TOPIC: begin
                    n_rem   = w_rem_dec;
                    n_topic = w_topic_dec;
                    if (w_dec_zero) begin
                        n_phase = PH_HEADER;
                    end else if (w_topic_dec == 16'd0) begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_rem = w_rem_dec;
                    if (w_dec_zero) begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_SKIP: begin
                    n_rem = w_rem_dec;
                    if (w_dec_zero) begin
                        n_phase = PH_HEADER;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_kind  <= 4'd0;
            r_rem   <= 28'd0;
            r_grp   <= 3'd0;
            r_hbc   <= 3'd0;
            r_topic <= 16'd0;
            r_drop  <= 1'b0;
            r_idle  <= 17'd0;
        end else if (w_in_acc) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_rem   <= n_rem;
            r_grp   <= n_grp;
            r_hbc   <= n_hbc;
            r_topic <= n_topic;
            r_drop  <= n_drop;
            r_idle  <= n_idle;
        end
    end

    // ------------------------------------------------------------------------
    // Result queue: room for two more results is needed to take an item.
    // ------------------------------------------------------------------------
    assign s_axis_tready = (r_cnt <= 3'd2);
    assign m_axis_tvalid = (r_cnt != 3'd0);
    assign m_axis_tdata  = {7'd0, r_q[r_rp].topic_end, r_q[r_rp].data};
    assign m_axis_tuser  = r_q[r_rp].kind;
    assign m_axis_tlast  = r_q[r_rp].packet_end;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            if (w_res_cnt != 2'd0) begin
                r_q[r_wp] <= w_res0;
            end
            if (w_res_cnt == 2'd2) begin
                r_q[r_wp + 2'd1] <= w_res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (w_in_acc) begin
                r_wp <= r_wp + w_res_cnt;
            end
            if (w_out_acc) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + (w_in_acc ? {1'b0, w_res_cnt} : 3'd0)
                           - {2'd0, w_out_acc};
        end
    end

endmodule

// File: verif/mqtt_inbound_deframer_keepalive_tb.sv
// ----------------------------------------------------------------------------
// MQTT inbound deframer with keepalive: testbench
// Feeds received bytes and time ticks into the stream input and predicts the
// topic, payload and transmit beats cycle-free. Covers publish framing, ping
// handling, skipped and oversized packets, length encodings and the keepalive
// timer, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module mqtt_inbound_deframer_keepalive_tb;
    import mqttdf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic       MODE_BYTE       = 1'b0;
    localparam logic       MODE_TICK       = 1'b1;
    localparam logic [3:0] TYPE_SUBSCRIBE  = 4'd8;
    localparam logic [3:0] TYPE_DISCONNECT = 4'd14;

    // The limit covers the slowest correct run: every beat meeting the longest
    // input gap and every result beat meeting the longest output stall.
    localparam int unsigned CYCLE_LIMIT   = 200_000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned MAX_REPORTS   = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    mqtt_inbound_deframer_keepalive dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte
        .s_axis_tuser  (s_axis_tuser),   // [0] mode
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] out_byte, [8] topic_end, rest zero
        .m_axis_tuser  (m_axis_tuser),   // [1:0] out_kind
        .m_axis_tlast  (m_axis_tlast),   // packet_end
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Parser and timer state as the block should hold it.
    t_phase      ph = PH_HEADER;
    logic [3:0]  pkt_type = '0;
    logic [27:0] remain = '0;
    logic [2:0]  grp_idx = '0;
    logic [2:0]  hdr_len = '0;
    logic [15:0] topic_left = '0;
    logic        drop_pkt = 1'b0;
    logic [16:0] idle_cnt = '0;
    logic [15:0] cfg_keepalive = KEEPALIVE_RST;
    logic [15:0] cfg_max_bytes = MAX_BYTES_RST;

    t_result     deliveries_due[$];
    logic [7:0]  frame_q[$];

    int unsigned items_sent = 0;
    int unsigned beats_checked = 0;
    int unsigned ping_count = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    bit          no_idle = 1'b0;

    function automatic void emit(input logic [1:0] kind, input logic [7:0] data,
                                 input logic tend, input logic pend);
        t_result r;
        r.kind       = kind;
        r.data       = data;
        r.topic_end  = tend;
        r.packet_end = pend;
        deliveries_due.push_back(r);
    endfunction

    function automatic void emit_tx_pair(input logic [7:0] first);
        emit(KIND_TX, first, 1'b0, 1'b0);
        emit(KIND_TX, 8'h00, 1'b0, 1'b1);
        idle_cnt = '0;
        if (first == BYTE_PINGREQ) ping_count++;
    endfunction

    function automatic void close_packet();
        ph = PH_HEADER;
        if (!drop_pkt && pkt_type == TYPE_PINGREQ) emit_tx_pair(BYTE_PINGRESP);
    endfunction

    function automatic void length_done();
        logic [28:0] total;
        total = 29'(hdr_len) + 29'(remain);
        drop_pkt = total > 29'(cfg_max_bytes);
        if (remain == '0) begin
            close_packet();
        end else if (drop_pkt || pkt_type != TYPE_PUBLISH) begin
            ph = PH_SKIP;
        end else begin
            ph = PH_TLEN_HI;
        end
    endfunction

    // One accepted input beat: a received byte or a time tick.
    function automatic void mqtt_parse_step(input logic mode, input logic [7:0] b);
        logic pend;
        if (mode == MODE_TICK) begin
            if (idle_cnt < IDLE_MAX) idle_cnt++;
            if (idle_cnt > {1'b0, cfg_keepalive}) emit_tx_pair(BYTE_PINGREQ);
            return;
        end
        case (ph)
            PH_HEADER: begin
                pkt_type   = b[7:4];
                remain     = '0;
                grp_idx    = '0;
                hdr_len    = 3'd1;
                topic_left = '0;
                drop_pkt   = 1'b0;
                ph         = PH_LENGTH;
            end
            PH_LENGTH: begin
                remain = remain | (28'(b[6:0]) << (7 * grp_idx[1:0]));
                grp_idx++;
                hdr_len++;
                // A fourth group ends the length whatever its continuation bit.
                if (!b[7] || grp_idx >= 3'd4) length_done();
            end
            PH_TLEN_HI: begin
                topic_left = {b, 8'h00};
                remain--;
                if (remain == '0) close_packet();
                else ph = PH_TLEN_LO;
            end
            PH_TLEN_LO: begin
                topic_left = {topic_left[15:8], b};
                remain--;
                if (remain == '0) close_packet();
                else ph = (topic_left == 16'd0) ? PH_PAYLOAD : PH_TOPIC;
            end
            PH_TOPIC: begin
                remain--;
                topic_left--;
                pend = (remain == '0);
                emit(KIND_TOPIC, b, (topic_left == 16'd0) || pend, pend);
                if (pend) ph = PH_HEADER;
                else if (topic_left == 16'd0) ph = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                remain--;
                pend = (remain == '0);
                emit(KIND_PAYLOAD, b, 1'b0, pend);
                if (pend) ph = PH_HEADER;
            end
            PH_SKIP: begin
                remain--;
                if (remain == '0) close_packet();
            end
            default: ph = PH_HEADER;
        endcase
    endfunction

    task automatic send_item(input logic mode, input logic [7:0] b);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        mqtt_parse_step(mode, b);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(MODE_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_frame(input int unsigned tick_pct);
        foreach (frame_q[i]) begin
            if ($urandom_range(0, 99) < tick_pct) send_tick();
            send_item(MODE_BYTE, frame_q[i]);
        end
    endtask

    task automatic send_bytes(input logic [7:0] bytes[$], input int unsigned tick_pct);
        frame_q = bytes;
        send_frame(tick_pct);
    endtask

    // Header byte plus the remaining length, sometimes in more groups than needed.
    task automatic frame_begin(input logic [7:0] hdr, input int unsigned rlen);
        int unsigned groups, min_groups;
        logic [7:0]  g;
        min_groups = (rlen < 128) ? 1 : (rlen < 16384) ? 2 : 3;
        groups = ($urandom_range(0, 3) == 0) ? $urandom_range(min_groups, 4) : min_groups;
        frame_q.delete();
        frame_q.push_back(hdr);
        for (int i = 0; i < groups; i++) begin
            g = 8'((rlen >> (7 * i)) & 32'h7F);
            if (i < groups - 1 || (i == 3 && $urandom_range(0, 1) == 1)) g[7] = 1'b1;
            frame_q.push_back(g);
        end
    endtask

    task automatic fill_random(input int unsigned n);
        repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic frame_publish(input logic [3:0] flags, input logic [15:0] tlen,
                                 input int unsigned rlen);
        frame_begin({TYPE_PUBLISH, flags}, rlen);
        if (rlen > 0) frame_q.push_back(tlen[15:8]);
        if (rlen > 1) frame_q.push_back(tlen[7:0]);
        if (rlen > 2) fill_random(rlen - 2);
    endtask

    task automatic wait_all_out();
        s_axis_tvalid <= 1'b0;
        while (deliveries_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [15:0] value);
        wait_all_out();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_KEEPALIVE) cfg_keepalive = value;
        else if (addr == ADDR_MAX_BYTES) cfg_max_bytes = value;
    endtask

    task automatic check_reg(input logic [2:0] addr, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {16'h0000, value}) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("Register read at %0d: expected %04h, got %08h",
                         addr, value, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_reset_keepalive();
        check_reg(ADDR_KEEPALIVE, KEEPALIVE_RST);
        check_reg(ADDR_MAX_BYTES, MAX_BYTES_RST);
        // A handful of ticks stays far below the reset keepalive.
        no_idle = 1'b1;
        repeat (20) send_tick();
        no_idle = 1'b0;
    endtask

    task automatic test_publish_frames();
        send_bytes('{{TYPE_PUBLISH, 4'h0}, 8'h05, 8'h00, 8'h02, 8'h00, 8'hFF, 8'hA5}, 0);
        // Flags set: any message id bytes still arrive as payload.
        send_bytes('{{TYPE_PUBLISH, 4'hF}, 8'h04, 8'h00, 8'h00, 8'h12, 8'h34}, 0);
        send_bytes('{{TYPE_PUBLISH, 4'h0}, 8'h03, 8'h00, 8'h01, 8'h41}, 0);
        send_bytes('{{TYPE_PUBLISH, 4'h0}, 8'h00}, 0);
    endtask

    task automatic test_special_packets();
        send_bytes('{{TYPE_PINGREQ, 4'h0}, 8'h00}, 0);
        send_bytes('{{TYPE_PINGREQ, 4'h0}, 8'h02, 8'h11, 8'h22}, 0);
        send_bytes('{{TYPE_PUBLISH, 4'h0}, 8'h01, 8'h00}, 0);
        send_bytes('{{TYPE_PUBLISH, 4'h0}, 8'h03, 8'h00, 8'h05, 8'h41}, 0);
        send_bytes('{{TYPE_PUBLISH, 4'h0}, 8'h84, 8'h80, 8'h80, 8'h80,
                     8'h00, 8'h01, 8'h5A, 8'h7E}, 0);
        send_bytes('{{TYPE_SUBSCRIBE, 4'h2}, 8'h02, 8'hAB, 8'hCD}, 0);
        send_bytes('{{TYPE_DISCONNECT, 4'h0}, 8'h00}, 0);
        send_bytes('{{TYPE_PUBLISH, 4'h0}, 8'h06, 8'h00, 8'h02, 8'h61, 8'h62, 8'h63, 8'h64}, 50);
    endtask

    task automatic test_size_limit();
        write_reg(ADDR_MAX_BYTES, 16'd7);
        send_bytes('{{TYPE_PUBLISH, 4'h0}, 8'h05, 8'h00, 8'h01, 8'h41, 8'h42, 8'h43}, 0);
        send_bytes('{{TYPE_PUBLISH, 4'h0}, 8'h06, 8'h00, 8'h01, 8'h41, 8'h42, 8'h43, 8'h44}, 0);
        // Padded length encoding makes the header one byte longer.
        send_bytes('{{TYPE_PUBLISH, 4'h0}, 8'h85, 8'h00, 8'h00, 8'h01, 8'h41, 8'h42, 8'h43}, 0);
        write_reg(ADDR_MAX_BYTES, 16'd4);
        send_bytes('{{TYPE_PINGREQ, 4'h0}, 8'h03, 8'h01, 8'h02, 8'h03}, 0);
        send_bytes('{{TYPE_PINGREQ, 4'h0}, 8'h02, 8'h01, 8'h02}, 0);
        write_reg(ADDR_MAX_BYTES, 16'hFFFF);
        frame_publish(4'h0, 16'd3, 130);
        send_frame(0);
    endtask

    task automatic test_keepalive_limits();
        write_reg(ADDR_KEEPALIVE, 16'd0);
        repeat (3) send_tick();
        write_reg(ADDR_KEEPALIVE, 16'd1);
        repeat (4) send_tick();
        write_reg(ADDR_KEEPALIVE, 16'hFFFF);
        no_idle = 1'b1;
        repeat (40) send_tick();
        no_idle = 1'b0;
    endtask

    task automatic run_random_traffic(input int unsigned n_items);
        int unsigned stop_at, pick, tlen, plen, rlen;
        logic [3:0]  flags;
        logic [15:0] tlen_field;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            no_idle = ($urandom_range(0, 4) == 0);
            pick  = $urandom_range(0, 99);
            flags = 4'($urandom_range(0, 15));
            tlen  = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
            plen  = $urandom_range(0, 10);
            frame_q.delete();
            if (pick < 55) begin
                frame_publish(flags, 16'(tlen), 2 + tlen + plen);
            end else if (pick < 65) begin
                rlen = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
                frame_begin({TYPE_PINGREQ, flags}, rlen);
                fill_random(rlen);
            end else if (pick < 75) begin
                // The packet may end inside its topic length or its topic.
                tlen_field = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(1, 65535))
                                                          : 16'(tlen + 1);
                frame_publish(flags, tlen_field, $urandom_range(0, 2 + tlen));
            end else if (pick < 85) begin
                rlen = $urandom_range(0, 6);
                frame_begin(8'($urandom_range(0, 255)), rlen);
                fill_random(rlen);
            end else if (pick < 95) begin
                repeat ($urandom_range(1, 6)) send_tick();
            end else if (cfg_max_bytes <= 16'd200) begin
                // Straddles the size limit.
                frame_publish(flags, 16'd1, int'(cfg_max_bytes) - 3 + $urandom_range(0, 3));
            end else begin
                frame_publish(flags, 16'(tlen), 2 + tlen + plen);
            end
            send_frame(10);
        end
        no_idle = 1'b0;
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run exceeded %0d cycles with %0d beats still due.",
                     CYCLE_LIMIT, deliveries_due.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int unsigned stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    t_result due;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (deliveries_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected result beat: kind %0d tdata %04h tlast %0d",
                             m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end else begin
                due = deliveries_due.pop_front();
                beats_checked++;
                if (m_axis_tuser !== due.kind || m_axis_tlast !== due.packet_end ||
                    m_axis_tdata !== {7'b0, due.topic_end, due.data}) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"Result beat %0d: expected kind %0d byte %02h topic_end %0d",
                                  " packet_end %0d, got kind %0d tdata %04h tlast %0d"},
                                 beats_checked, due.kind, due.data, due.topic_end,
                                 due.packet_end, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_keepalive();
        test_publish_frames();
        test_special_packets();
        test_size_limit();
        test_keepalive_limits();

        write_reg(ADDR_KEEPALIVE, 16'd8);
        write_reg(ADDR_MAX_BYTES, 16'd40);
        run_random_traffic(100);
        write_reg(ADDR_KEEPALIVE, 16'd3);
        write_reg(ADDR_MAX_BYTES, 16'd24);
        run_random_traffic(100);
        write_reg(ADDR_KEEPALIVE, 16'd20);
        write_reg(ADDR_MAX_BYTES, 16'hFFFF);
        run_random_traffic(100);

        wait_all_out();
        $display("Sent %0d input beats and checked %0d result beats, %0d of them keepalive pings.",
                 items_sent, beats_checked, 2 * ping_count);
        $display("Covered publish framing, pings, skipped and oversized packets, padded lengths %s",
                 "and the keepalive limits.");
        if (mismatches == 0 && deliveries_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
src/mqttdf_pkg.sv
src/mqtt_inbound_deframer_keepalive.sv
verif/mqtt_inbound_deframer_keepalive_tb.sv
